[rtl/zbtr_pkg.sv]
`default_nettype none

package zbtr_pkg;

  // Field widths of the request and result channels
  localparam int CoordW   = 12;
  localparam int DepthInW = 16;
  localparam int ColorW   = 32;
  localparam int AddrInW  = 16;
  localparam int CountW   = 17;
  localparam int CfgW     = 9;
  localparam int DepthW   = 32;
  localparam int StatusW  = 2;

  // Internal arithmetic widths
  localparam int DiffW  = CoordW + 1;         // vertex differences
  localparam int AreaW  = 2 * DiffW + 2;      // signed doubled area
  localparam int AbsW   = AreaW - 1;          // area magnitude, edge weights
  localparam int EdgeW  = 32;                 // edge function values
  localparam int ProdW  = DepthInW + AbsW + 1;
  localparam int AccW   = ProdW + 2;          // sum of three weighted depths
  localparam int QuotW  = 24;                 // |depth| <= 2^23
  localparam int RemW   = AccW + 8;
  localparam int WordW  = ColorW + DepthW;    // {colour, depth} store word

  // Defaults and sizes
  localparam int MaxWidthDef   = 256;
  localparam int MaxHeightDef  = 256;
  localparam int JobQueueDepth = 2;
  localparam int FrameResetVal = 256;

  localparam logic [DepthW-1:0] DepthEmpty = 32'h8000_0000;

  // Result status codes
  localparam logic [StatusW-1:0] StDrawn = 2'd0;
  localparam logic [StatusW-1:0] StDegen = 2'd1;
  localparam logic [StatusW-1:0] StRead  = 2'd2;

  // Register index codes
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  typedef enum logic [1:0] {
    JOB_READ,
    JOB_DRAW,
    JOB_DEGEN,
    JOB_EMPTY
  } job_kind_e;

  typedef logic signed [CoordW-1:0]   coord_t;
  typedef logic signed [EdgeW-1:0]    edge_t;
  typedef logic signed [DepthInW-1:0] zin_t;

  // Classified request handed from front to back
  typedef struct packed {
    job_kind_e            kind;
    logic [AddrInW-1:0]   addr;
    logic [ColorW-1:0]    color;
    coord_t               x0;
    coord_t               x1;
    coord_t               y0;
    coord_t               y1;
    logic                 neg;
    logic [AbsW-1:0]      aabs;
    edge_t                f0;
    edge_t                f1;
    edge_t                f2;
    edge_t                dx0;
    edge_t                dx1;
    edge_t                dx2;
    edge_t                dy0;
    edge_t                dy1;
    edge_t                dy2;
    zin_t                 z0;
    zin_t                 z1;
    zin_t                 z2;
  } job_t;

endpackage

`default_nettype wire

[rtl/zbtr_front.sv]
`default_nettype none

module zbtr_front import zbtr_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  localparam int WW = $clog2(MaxWidth + 1),
  localparam int HW = $clog2(MaxHeight + 1)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               clearing_i,
  input  wire logic               command_i,
  input  wire coord_t             vert0_x_i,
  input  wire coord_t             vert0_y_i,
  input  wire zin_t               vert0_z_i,
  input  wire coord_t             vert1_x_i,
  input  wire coord_t             vert1_y_i,
  input  wire zin_t               vert1_z_i,
  input  wire coord_t             vert2_x_i,
  input  wire coord_t             vert2_y_i,
  input  wire zin_t               vert2_z_i,
  input  wire logic [ColorW-1:0]  fill_color_i,
  input  wire logic [AddrInW-1:0] pixel_addr_i,
  input  wire logic [WW-1:0]      w_eff_i,
  input  wire logic [HW-1:0]      h_eff_i,
  output logic                    push_o,
  output job_t                    job_o,
  input  wire logic               full_i
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_AREA = 4'b0010,
    F_EDGE = 4'b0100,
    F_PUSH = 4'b1000
  } fr_state_e;

  fr_state_e state_q, state_d;

  logic               cmd_q;
  coord_t             ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  zin_t               az_q, bz_q, cz_q;
  logic [ColorW-1:0]  color_q;
  logic [AddrInW-1:0] addr_q;

  logic signed [DiffW-1:0] sx0_q, sx1_q, sy0_q, sy1_q;
  logic signed [AreaW-1:0] area_q;
  logic signed [DiffW-1:0] x0_q, x1_q, y0_q, y1_q;
  logic                    empty_q;
  edge_t                   f1_q, f2_q;

  logic accept;
  assign in_stall_o = (state_q != F_IDLE) || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Area and clamped bounding box
  logic signed [DiffW-1:0]     sx0, sx1, sy0, sy1;
  logic signed [2*DiffW-1:0]   pa, pb;
  logic signed [AreaW-1:0]     area_d;
  coord_t                      mnx, mxx, mny, mxy;
  logic signed [DiffW-1:0]     wm1, hm1, x0c, x1c, y0c, y1c;

  always_comb begin
    sx0 = DiffW'(cx_q) - DiffW'(ax_q);
    sx1 = DiffW'(bx_q) - DiffW'(ax_q);
    sy0 = DiffW'(cy_q) - DiffW'(ay_q);
    sy1 = DiffW'(by_q) - DiffW'(ay_q);
    pa  = sx0 * sy1;
    pb  = sx1 * sy0;
    area_d = AreaW'(pa) - AreaW'(pb);
    mnx = (ax_q < bx_q) ? ax_q : bx_q;
    mnx = (mnx < cx_q) ? mnx : cx_q;
    mxx = (ax_q > bx_q) ? ax_q : bx_q;
    mxx = (mxx > cx_q) ? mxx : cx_q;
    mny = (ay_q < by_q) ? ay_q : by_q;
    mny = (mny < cy_q) ? mny : cy_q;
    mxy = (ay_q > by_q) ? ay_q : by_q;
    mxy = (mxy > cy_q) ? mxy : cy_q;
    wm1 = $signed(DiffW'(w_eff_i)) - DiffW'(1);
    hm1 = $signed(DiffW'(h_eff_i)) - DiffW'(1);
    x0c = (mnx < 0) ? '0 : DiffW'(mnx);
    y0c = (mny < 0) ? '0 : DiffW'(mny);
    x1c = (DiffW'(mxx) > wm1) ? wm1 : DiffW'(mxx);
    y1c = (DiffW'(mxy) > hm1) ? hm1 : DiffW'(mxy);
  end

  // Edge functions at the top left corner of the box
  logic signed [DiffW-1:0]   sx2, sy2;
  logic signed [2*DiffW-1:0] pc, pd, pe, pf;

  always_comb begin
    sx2 = DiffW'(ax_q) - x0_q;
    sy2 = DiffW'(ay_q) - y0_q;
    pc  = sx1_q * sy2;
    pd  = sx2 * sy1_q;
    pe  = sx2 * sy0_q;
    pf  = sx0_q * sy2;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = command_i ? F_PUSH : F_AREA;
      F_AREA: state_d = F_EDGE;
      F_EDGE: state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the request and the setup terms
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= command_i;
      ax_q    <= vert0_x_i;
      ay_q    <= vert0_y_i;
      az_q    <= vert0_z_i;
      bx_q    <= vert1_x_i;
      by_q    <= vert1_y_i;
      bz_q    <= vert1_z_i;
      cx_q    <= vert2_x_i;
      cy_q    <= vert2_y_i;
      cz_q    <= vert2_z_i;
      color_q <= fill_color_i;
      addr_q  <= pixel_addr_i;
    end
    if (state_q == F_AREA) begin
      sx0_q   <= sx0;
      sx1_q   <= sx1;
      sy0_q   <= sy0;
      sy1_q   <= sy1;
      area_q  <= area_d;
      x0_q    <= x0c;
      x1_q    <= x1c;
      y0_q    <= y0c;
      y1_q    <= y1c;
      empty_q <= (x0c > x1c) || (y0c > y1c);
    end
    if (state_q == F_EDGE) begin
      f2_q <= EdgeW'(pc) - EdgeW'(pd);
      f1_q <= EdgeW'(pe) - EdgeW'(pf);
    end
  end

  // Build the job
  logic signed [AreaW-1:0] area_abs;
  assign area_abs = area_q[AreaW-1] ? -area_q : area_q;

  always_comb begin
    if (cmd_q) begin
      job_o.kind = JOB_READ;
    end else if (area_q == '0) begin
      job_o.kind = JOB_DEGEN;
    end else if (empty_q) begin
      job_o.kind = JOB_EMPTY;
    end else begin
      job_o.kind = JOB_DRAW;
    end
    job_o.addr  = addr_q;
    job_o.color = color_q;
    job_o.x0    = CoordW'(x0_q);
    job_o.x1    = CoordW'(x1_q);
    job_o.y0    = CoordW'(y0_q);
    job_o.y1    = CoordW'(y1_q);
    job_o.neg   = area_q[AreaW-1];
    job_o.aabs  = AbsW'(area_abs);
    job_o.f0    = EdgeW'(area_q) - f1_q - f2_q;
    job_o.f1    = f1_q;
    job_o.f2    = f2_q;
    job_o.dx0   = EdgeW'(sy0_q) - EdgeW'(sy1_q);
    job_o.dx1   = -EdgeW'(sy0_q);
    job_o.dx2   = EdgeW'(sy1_q);
    job_o.dy0   = EdgeW'(sx1_q) - EdgeW'(sx0_q);
    job_o.dy1   = EdgeW'(sx0_q);
    job_o.dy2   = -EdgeW'(sx1_q);
    job_o.z0    = az_q;
    job_o.z1    = bz_q;
    job_o.z2    = cz_q;
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

endmodule

`default_nettype wire

[rtl/zbtr_queue.sv]
`default_nettype none

module zbtr_queue import zbtr_pkg::*; #(
  parameter int Depth = JobQueueDepth,
  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CW = $clog2(Depth + 1)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output job_t      data_o,
  output logic      empty_o
);

  job_t            slot_q [Depth];
  logic [PW-1:0]   wr_q, rd_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
      if (pop_i)  rd_q <= (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CW'(1);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i |-> !full_o) and (pop_i |-> !empty_o))
    else $error("job queue overflow or underflow");
`endif

endmodule

`default_nettype wire

[rtl/zbtr_back.sv]
`default_nettype none

module zbtr_back import zbtr_pkg::*; #(
  parameter int MaxWidth  = MaxWidthDef,
  parameter int MaxHeight = MaxHeightDef,
  localparam int WW    = $clog2(MaxWidth + 1),
  localparam int Store = MaxWidth * MaxHeight,
  localparam int AW    = $clog2(Store)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire job_t                job_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  input  wire logic [WW-1:0]       w_eff_i,
  output logic                     clearing_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic [CountW-1:0]        pixels_written_o,
  output logic [ColorW-1:0]        read_color_o,
  output logic signed [DepthW-1:0] read_depth_o
);

  localparam int DCW     = $clog2(QuotW);
  localparam int MulLast = 2;

  typedef enum logic [10:0] {
    B_CLEAR = 11'b000_0000_0001,
    B_IDLE  = 11'b000_0000_0010,
    B_READ  = 11'b000_0000_0100,
    B_RDATA = 11'b000_0000_1000,
    B_SETUP = 11'b000_0001_0000,
    B_TEST  = 11'b000_0010_0000,
    B_MUL   = 11'b000_0100_0000,
    B_DIVI  = 11'b000_1000_0000,
    B_DIV   = 11'b001_0000_0000,
    B_CMP   = 11'b010_0000_0000,
    B_RES   = 11'b100_0000_0000
  } bk_state_e;

  bk_state_e state_q, state_d;

  job_t                     job_q;
  logic [AW-1:0]            clr_q;
  coord_t                   px_q, py_q;
  logic [AW-1:0]            row_base_q;
  edge_t                    fr0_q, fr1_q, fr2_q, fc0_q, fc1_q, fc2_q;
  logic [AbsW-1:0]          e0_q, e1_q, e2_q;
  logic [1:0]               mul_cnt_q;
  logic signed [AccW-1:0]   acc_q;
  logic                     acc_neg_q;
  logic [RemW-1:0]          rem_q, dsr_q;
  logic [QuotW-1:0]         quo_q;
  logic [DCW-1:0]           div_cnt_q;
  logic [CountW-1:0]        cnt_q;
  logic [WordW-1:0]         mem_q [Store];
  logic [WordW-1:0]         rdata_q;
  logic                     out_valid_q;

  // Store ports
  logic                 we, re;
  logic [AW-1:0]        waddr, raddr;
  logic [WordW-1:0]     wdata;

  logic can_out, covered, last_x, last_y, step_px, addr_ok, better, load_out;
  logic [AW-1:0]            idx;
  logic [AbsW-1:0]          e0, e1, e2;
  logic [CoordW+WW-1:0]     rb;
  zin_t                     zsel;
  logic [AbsW-1:0]          esel;
  logic signed [ProdW-1:0]  prod;
  logic [AccW-1:0]          acc_mag;
  logic [DepthW-1:0]        zq, zval;
  logic                     ge;

  logic [StatusW-1:0]       res_status;
  logic [CountW-1:0]        res_count;
  logic [ColorW-1:0]        res_color;
  logic [DepthW-1:0]        res_depth;

  assign can_out = !out_valid_q || !out_stall_i;
  assign addr_ok = (32'(job_q.addr) < 32'(Store));
  assign idx     = row_base_q + AW'(32'(px_q[CoordW-1:0]));
  assign last_x  = (px_q == job_q.x1);
  assign last_y  = (py_q == job_q.y1);
  assign rb      = job_q.y0[CoordW-1:0] * w_eff_i;

  // Coverage test: each edge weight carries the sign of the area or is zero
  always_comb begin
    if (job_q.neg) begin
      covered = (fc0_q <= 0) && (fc1_q <= 0) && (fc2_q <= 0);
      e0 = AbsW'(-fc0_q);
      e1 = AbsW'(-fc1_q);
      e2 = AbsW'(-fc2_q);
    end else begin
      covered = (fc0_q >= 0) && (fc1_q >= 0) && (fc2_q >= 0);
      e0 = AbsW'(fc0_q);
      e1 = AbsW'(fc1_q);
      e2 = AbsW'(fc2_q);
    end
  end

  // One weighted depth a cycle
  always_comb begin
    case (mul_cnt_q)
      2'd0:    begin zsel = job_q.z0; esel = e0_q; end
      2'd1:    begin zsel = job_q.z1; esel = e1_q; end
      default: begin zsel = job_q.z2; esel = e2_q; end
    endcase
    prod = zsel * $signed({1'b0, esel});
  end

  // Divider step and the finished depth
  always_comb begin
    acc_mag = acc_q[AccW-1] ? AccW'(-acc_q) : AccW'(acc_q);
    ge      = (rem_q >= dsr_q);
    zq      = DepthW'(quo_q);
    zval    = acc_neg_q ? -zq : zq;
    better  = $signed(rdata_q[DepthW-1:0]) < $signed(zval);
  end

  assign step_px = ((state_q == B_TEST) && !covered) || (state_q == B_CMP);

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;
    load_out   = 1'b0;
    res_status = StDrawn;
    res_count  = '0;
    res_color  = '0;
    res_depth  = '0;
    unique case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = {{ColorW{1'b0}}, DepthEmpty};
        if (clr_q == AW'(Store - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (job_i.kind)
            JOB_READ: state_d = B_READ;
            JOB_DRAW: state_d = B_SETUP;
            default:  state_d = B_RES;
          endcase
        end
      end
      B_READ: begin
        re      = addr_ok;
        raddr   = AW'(32'(job_q.addr));
        state_d = B_RDATA;
      end
      B_RDATA: begin
        res_status = StRead;
        res_color  = addr_ok ? rdata_q[WordW-1:DepthW] : '0;
        res_depth  = addr_ok ? rdata_q[DepthW-1:0] : DepthEmpty;
        if (can_out) begin
          load_out = 1'b1;
          we       = addr_ok;
          waddr    = AW'(32'(job_q.addr));
          wdata    = {{ColorW{1'b0}}, DepthEmpty};
          state_d  = B_IDLE;
        end
      end
      B_SETUP: state_d = B_TEST;
      B_TEST: begin
        if (covered) begin
          re      = 1'b1;
          raddr   = idx;
          state_d = B_MUL;
        end else if (last_x && last_y) begin
          state_d = B_RES;
        end
      end
      B_MUL: if (mul_cnt_q == 2'(MulLast)) state_d = B_DIVI;
      B_DIVI: state_d = B_DIV;
      B_DIV: if (div_cnt_q == DCW'(QuotW - 1)) state_d = B_CMP;
      B_CMP: begin
        we      = better;
        waddr   = idx;
        wdata   = {job_q.color, zval};
        state_d = (last_x && last_y) ? B_RES : B_TEST;
      end
      B_RES: begin
        res_status = (job_q.kind == JOB_DEGEN) ? StDegen : StDrawn;
        res_count  = cnt_q;
        if (can_out) begin
          load_out = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + AW'(1);
      if (load_out)           out_valid_q <= 1'b1;
      else if (!out_stall_i)  out_valid_q <= 1'b0;
    end
  end

  // Depth and colour store
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rdata_q <= mem_q[raddr];
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o         <= res_status;
      pixels_written_o <= res_count;
      read_color_o     <= res_color;
      read_depth_o     <= $signed(res_depth);
    end
  end

  // Walk, weight and divide
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          job_q <= job_i;
          cnt_q <= '0;
        end
      end
      B_SETUP: begin
        row_base_q <= AW'(rb);
        px_q  <= job_q.x0;
        py_q  <= job_q.y0;
        fr0_q <= job_q.f0;
        fr1_q <= job_q.f1;
        fr2_q <= job_q.f2;
        fc0_q <= job_q.f0;
        fc1_q <= job_q.f1;
        fc2_q <= job_q.f2;
      end
      B_TEST: begin
        if (covered) begin
          e0_q      <= e0;
          e1_q      <= e1;
          e2_q      <= e2;
          acc_q     <= '0;
          mul_cnt_q <= '0;
        end
      end
      B_MUL: begin
        acc_q     <= acc_q + AccW'(prod);
        mul_cnt_q <= mul_cnt_q + 2'd1;
      end
      B_DIVI: begin
        rem_q     <= RemW'(acc_mag) << 8;
        dsr_q     <= RemW'(job_q.aabs) << (QuotW - 1);
        quo_q     <= '0;
        div_cnt_q <= '0;
        acc_neg_q <= acc_q[AccW-1];
      end
      B_DIV: begin
        if (ge) rem_q <= rem_q - dsr_q;
        quo_q     <= {quo_q[QuotW-2:0], ge};
        dsr_q     <= dsr_q >> 1;
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
      B_CMP: begin
        if (better && (cnt_q != '1)) cnt_q <= cnt_q + CountW'(1);
      end
      default: ;
    endcase

    // Step to the next pixel of the box
    if (step_px) begin
      if (!last_x) begin
        px_q  <= px_q + CoordW'(1);
        fc0_q <= fc0_q + job_q.dx0;
        fc1_q <= fc1_q + job_q.dx1;
        fc2_q <= fc2_q + job_q.dx2;
      end else if (!last_y) begin
        px_q       <= job_q.x0;
        py_q       <= py_q + CoordW'(1);
        row_base_q <= row_base_q + AW'(w_eff_i);
        fr0_q      <= fr0_q + job_q.dy0;
        fr1_q      <= fr1_q + job_q.dy1;
        fr2_q      <= fr2_q + job_q.dy2;
        fc0_q      <= fr0_q + job_q.dy0;
        fc1_q      <= fr1_q + job_q.dy1;
        fc2_q      <= fr2_q + job_q.dy2;
      end
    end
  end

  assign clearing_o  = (state_q == B_CLEAR);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_quot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CMP) |-> (quo_q <= QuotW'(24'h80_0000)))
    else $error("interpolated depth magnitude out of range");

  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> (!out_valid_q && !pop_o))
    else $error("activity during store clearing pass");

  a_count_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((pixels_written_o == '0) || (status_o == StDrawn)))
    else $error("pixel count reported with non-draw status");
`endif

endmodule

`default_nettype wire

[rtl/zbuffer_triangle_raster.sv]
// Read request: the entry is read from the store, then the result is posted and the
// entry reset; draw request: area, clamped bounding box and edge setup, then a walk of
// the box that weights each covered pixel's depth (three-step weighting, 24-step
// radix-2 depth divider) and depth-tests it, then the result is posted. One request is
// worked on at a time; a 2-entry job queue lets setup of the next request overlap the
// pixel walk. After reset the store is cleared one entry a cycle, with in_stall_o high.
`default_nettype none

module zbuffer_triangle_raster import zbtr_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                command_i,
  input  wire coord_t              vert0_x_i,
  input  wire coord_t              vert0_y_i,
  input  wire zin_t                vert0_z_i,
  input  wire coord_t              vert1_x_i,
  input  wire coord_t              vert1_y_i,
  input  wire zin_t                vert1_z_i,
  input  wire coord_t              vert2_x_i,
  input  wire coord_t              vert2_y_i,
  input  wire zin_t                vert2_z_i,
  input  wire logic [ColorW-1:0]   fill_color_i,
  input  wire logic [AddrInW-1:0]  pixel_addr_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [StatusW-1:0]       status_o,
  output logic [CountW-1:0]        pixels_written_o,
  output logic [ColorW-1:0]        read_color_o,
  output logic signed [DepthW-1:0] read_depth_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CfgW-1:0] width_q, height_q;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic            cfg_wr;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(FrameResetVal);
      height_q <= CfgW'(FrameResetVal);
    end else if (cfg_wr) begin
      if (paddr[2] == RegFrameWidth) width_q  <= pwdata[CfgW-1:0];
      else                           height_q <= pwdata[CfgW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegFrameHeight) ? 32'(height_q) : 32'(width_q);

  // Zero acts as one, saturate at the maximum
  always_comb begin
    if (width_q == '0)                          w_eff = WW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH))     w_eff = WW'(MAX_WIDTH);
    else                                        w_eff = WW'(32'(width_q));
    if (height_q == '0)                         h_eff = HW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT))   h_eff = HW'(MAX_HEIGHT);
    else                                        h_eff = HW'(32'(height_q));
  end

  logic clearing, push, full, pop, empty;
  job_t job_in, job_out;

  zbtr_front #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .clearing_i   (clearing),
    .command_i    (command_i),
    .vert0_x_i    (vert0_x_i),
    .vert0_y_i    (vert0_y_i),
    .vert0_z_i    (vert0_z_i),
    .vert1_x_i    (vert1_x_i),
    .vert1_y_i    (vert1_y_i),
    .vert1_z_i    (vert1_z_i),
    .vert2_x_i    (vert2_x_i),
    .vert2_y_i    (vert2_y_i),
    .vert2_z_i    (vert2_z_i),
    .fill_color_i (fill_color_i),
    .pixel_addr_i (pixel_addr_i),
    .w_eff_i      (w_eff),
    .h_eff_i      (h_eff),
    .push_o       (push),
    .job_o        (job_in),
    .full_i       (full)
  );

  zbtr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  zbtr_back #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_i            (job_out),
    .empty_i          (empty),
    .pop_o            (pop),
    .w_eff_i          (w_eff),
    .clearing_o       (clearing),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .pixels_written_o (pixels_written_o),
    .read_color_o     (read_color_o),
    .read_depth_o     (read_depth_o)
  );

endmodule

`default_nettype wire

[sim/zbtr_checker.sv]
`timescale 1ns / 100ps

module zbtr_checker import zbtr_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_o,
  input  wire logic                command_i,
  input  wire coord_t              vert0_x_i,
  input  wire coord_t              vert0_y_i,
  input  wire zin_t                vert0_z_i,
  input  wire coord_t              vert1_x_i,
  input  wire coord_t              vert1_y_i,
  input  wire zin_t                vert1_z_i,
  input  wire coord_t              vert2_x_i,
  input  wire coord_t              vert2_y_i,
  input  wire zin_t                vert2_z_i,
  input  wire logic [ColorW-1:0]   fill_color_i,
  input  wire logic [AddrInW-1:0]  pixel_addr_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_stall_i,
  input  wire logic [StatusW-1:0]  status_o,
  input  wire logic [CountW-1:0]   pixels_written_o,
  input  wire logic [ColorW-1:0]   read_color_o,
  input  wire logic signed [DepthW-1:0] read_depth_o,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       pixels_total_o,
  output int                       degen_seen_o
);

  localparam int StoreSize = MaxWidthDef * MaxHeightDef;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  count;
    logic [ColorW-1:0]  color;
    logic [DepthW-1:0]  depth;
  } raster_result_t;

  raster_result_t     due_results[$];
  logic [DepthW-1:0]  depth_mem [StoreSize];
  logic [ColorW-1:0]  color_mem [StoreSize];
  logic [CfgW-1:0]    width_reg;
  logic [CfgW-1:0]    height_reg;

  initial begin
    fail_count_o   = 0;
    pixels_total_o = 0;
    degen_seen_o   = 0;
    width_reg      = CfgW'(FrameResetVal);
    height_reg     = CfgW'(FrameResetVal);
    for (int i = 0; i < StoreSize; i++) begin
      depth_mem[i] = DepthEmpty;
      color_mem[i] = '0;
    end
  end

  assign pending_o = due_results.size();

  function automatic longint eff_size(logic [CfgW-1:0] r, int maxv);
    if (r == 0) return 1;
    return (r > maxv) ? maxv : r;
  endfunction

  // Walk the clamped box, depth-test covered pixels and update both stores
  function automatic raster_result_t rasterise_draw();
    raster_result_t res;
    longint ax, ay, az, bx, by, bz, cx, cy, cz;
    longint w, h, area, sgn, aabs, x0, x1, y0, y1;
    longint ux, uy, e0, e1, e2, z, idx;
    int count;
    ax = vert0_x_i; ay = vert0_y_i; az = vert0_z_i;
    bx = vert1_x_i; by = vert1_y_i; bz = vert1_z_i;
    cx = vert2_x_i; cy = vert2_y_i; cz = vert2_z_i;
    w = eff_size(width_reg, MaxWidthDef);
    h = eff_size(height_reg, MaxHeightDef);
    res.color = '0;
    res.depth = '0;
    res.count = '0;
    area = (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
    if (area == 0) begin
      res.status = StDegen;
      return res;
    end
    sgn  = (area < 0) ? -1 : 1;
    aabs = area * sgn;
    x0 = (ax < bx) ? ax : bx;  x0 = (x0 < cx) ? x0 : cx;
    x1 = (ax > bx) ? ax : bx;  x1 = (x1 > cx) ? x1 : cx;
    y0 = (ay < by) ? ay : by;  y0 = (y0 < cy) ? y0 : cy;
    y1 = (ay > by) ? ay : by;  y1 = (y1 > cy) ? y1 : cy;
    if (x0 < 0) x0 = 0;
    if (y0 < 0) y0 = 0;
    if (x1 > w - 1) x1 = w - 1;
    if (y1 > h - 1) y1 = h - 1;
    count = 0;
    for (longint px = x0; px <= x1; px++) begin
      for (longint py = y0; py <= y1; py++) begin
        ux = (bx - ax) * (ay - py) - (ax - px) * (by - ay);
        uy = (ax - px) * (cy - ay) - (cx - ax) * (ay - py);
        e0 = (area - ux - uy) * sgn;
        e1 = uy * sgn;
        e2 = ux * sgn;
        if (e0 < 0 || e1 < 0 || e2 < 0) continue;
        z   = ((az * e0 + bz * e1 + cz * e2) * 256) / aabs;
        idx = py * w + px;
        if (idx >= StoreSize) continue;
        if (longint'($signed(depth_mem[idx])) < z) begin
          depth_mem[idx] = z[31:0];
          color_mem[idx] = fill_color_i;
          if (count < (1 << CountW) - 1) count++;
        end
      end
    end
    res.status = StDrawn;
    res.count  = count[CountW-1:0];
    return res;
  endfunction

  // Return one entry and put it back to its reset contents
  function automatic raster_result_t read_and_clear();
    raster_result_t res;
    res.status = StRead;
    res.count  = '0;
    res.color  = '0;
    res.depth  = DepthEmpty;
    if (pixel_addr_i < StoreSize) begin
      res.color = color_mem[pixel_addr_i];
      res.depth = depth_mem[pixel_addr_i];
      color_mem[pixel_addr_i] = '0;
      depth_mem[pixel_addr_i] = DepthEmpty;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  // Track register writes
  always @(posedge clk_i) begin
    if (rst_ni && psel && penable && pwrite && pready) begin
      if (paddr[2] == RegFrameWidth) width_reg <= pwdata[CfgW-1:0];
      else height_reg <= pwdata[CfgW-1:0];
    end
  end

  // Predict each accepted request
  always @(posedge clk_i) begin
    raster_result_t res;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      res = command_i ? read_and_clear() : rasterise_draw();
      due_results.push_back(res);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    raster_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with no request outstanding", $realtime);
        fail_count_o++;
      end else begin
        want = due_results.pop_front();
        if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
        if (pixels_written_o !== want.count)
          flag_mismatch("pixels_written", pixels_written_o, want.count);
        if (read_color_o !== want.color)
          flag_mismatch("read_color", read_color_o, want.color);
        if (read_depth_o !== want.depth)
          flag_mismatch("read_depth", read_depth_o, want.depth);
        pixels_total_o += want.count;
        if (want.status == StDegen) degen_seen_o++;
      end
    end
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb import zbtr_pkg::*; ;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = 1'b0;
  coord_t             v0x = '0, v0y = '0, v1x = '0, v1y = '0, v2x = '0, v2y = '0;
  zin_t               v0z = '0, v1z = '0, v2z = '0;
  logic [ColorW-1:0]  fill_color = '0;
  logic [AddrInW-1:0] pixel_addr = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  pixels_written;
  logic [ColorW-1:0]  read_color;
  logic signed [DepthW-1:0] read_depth;
  int                 fail_count, pending, pixels_total, degen_seen;
  int                 n_draws = 0, n_reads = 0, n_settings = 1;
  int                 frame_w = 256, frame_h = 256;
  bit                 hold_req = 1'b0;

  always #5 clk = ~clk;

  zbuffer_triangle_raster dut (
    .clk_i(clk), .rst_ni(rst_n), .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .vert0_x_i(v0x), .vert0_y_i(v0y), .vert0_z_i(v0z),
    .vert1_x_i(v1x), .vert1_y_i(v1y), .vert1_z_i(v1z),
    .vert2_x_i(v2x), .vert2_y_i(v2y), .vert2_z_i(v2z),
    .fill_color_i(fill_color), .pixel_addr_i(pixel_addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .pixels_written_o(pixels_written), .read_color_o(read_color),
    .read_depth_o(read_depth)
  );

  zbtr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .psel, .penable, .pwrite, .paddr, .pwdata,
    .pready, .in_valid_i(in_valid), .in_stall_o(in_stall),
    .command_i(command), .vert0_x_i(v0x), .vert0_y_i(v0y), .vert0_z_i(v0z),
    .vert1_x_i(v1x), .vert1_y_i(v1y), .vert1_z_i(v1z),
    .vert2_x_i(v2x), .vert2_y_i(v2y), .vert2_z_i(v2z),
    .fill_color_i(fill_color), .pixel_addr_i(pixel_addr),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .status_o(status),
    .pixels_written_o(pixels_written), .read_color_o(read_color),
    .read_depth_o(read_depth), .fail_count_o(fail_count), .pending_o(pending),
    .pixels_total_o(pixels_total), .degen_seen_o(degen_seen)
  );

  // Offer one request, hold it until taken, then maybe drop valid for a gap
  task automatic send_req(input logic cmd, input int x0, y0, z0, x1, y1, z1,
                          x2, y2, z2, input logic [31:0] col, input logic [15:0] addr);
    int r, gap;
    command    <= cmd;
    v0x <= x0[11:0]; v0y <= y0[11:0]; v0z <= z0[15:0];
    v1x <= x1[11:0]; v1y <= y1[11:0]; v1z <= z1[15:0];
    v2x <= x2[11:0]; v2y <= y2[11:0]; v2z <= z2[15:0];
    fill_color <= col;
    pixel_addr <= addr;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (cmd) n_reads++; else n_draws++;
    r = $urandom_range(0, 99);
    gap = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic draw(input int x0, y0, z0, x1, y1, z1, x2, y2, z2,
                      input logic [31:0] col);
    send_req(1'b0, x0, y0, z0, x1, y1, z1, x2, y2, z2, col, 16'($urandom));
  endtask

  task automatic read_px(input logic [15:0] addr);
    send_req(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, addr);
  endtask

  // Wait until every outstanding request has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
  endtask

  task automatic write_frame(input logic [8:0] w, input logic [8:0] h);
    for (int i = 0; i < 2; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (i == 0) ? {RegFrameWidth, 2'b00} : {RegFrameHeight, 2'b00};
      pwdata  <= {23'($urandom), (i == 0) ? w : h};
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    frame_w = (w == 0) ? 1 : (w > 256) ? 256 : w;
    frame_h = (h == 0) ? 1 : (h > 256) ? 256 : h;
    n_settings++;
  endtask

  function automatic int full_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  function automatic int full_z();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random draw: mostly small triangles near the frame, some far-flung noise
  task automatic random_draw();
    int bx, by, r;
    r = $urandom_range(0, 99);
    if (r < 8 && frame_w * frame_h <= 64) begin
      draw(full_coord(), full_coord(), full_z(), full_coord(), full_coord(), full_z(),
           full_coord(), full_coord(), full_z(), $urandom);
    end else if (r < 8) begin
      // box lies wholly off the frame
      bx = ($urandom_range(0, 1)) ? 300 : -2048;
      draw(bx + $urandom_range(0, 1747), full_coord(), full_z(),
           bx + $urandom_range(0, 1747), full_coord(), full_z(),
           bx + $urandom_range(0, 1747), full_coord(), full_z(), $urandom);
    end else if (r < 13) begin
      bx = $urandom_range(0, frame_w);
      by = $urandom_range(0, frame_h);
      draw(bx, by, full_z(), bx + 2, by + 2, full_z(), bx + 5, by + 5, full_z(), $urandom);
    end else begin
      bx = int'($urandom_range(0, frame_w + 5)) - 3;
      by = int'($urandom_range(0, frame_h + 5)) - 3;
      draw(bx + $urandom_range(0, 9) - 2, by + $urandom_range(0, 9) - 2, full_z(),
           bx + $urandom_range(0, 9) - 2, by + $urandom_range(0, 9) - 2, full_z(),
           bx + $urandom_range(0, 9) - 2, by + $urandom_range(0, 9) - 2, full_z(),
           $urandom);
    end
  endtask

  task automatic random_read();
    if ($urandom_range(0, 9) < 8)
      read_px(16'($urandom_range(0, frame_h - 1) * frame_w + $urandom_range(0, frame_w - 1)));
    else
      read_px(16'($urandom));
  endtask

  // Result-side stall: short and long stretches, plus one long hold-off
  initial begin
    int r, n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        n = (r < 65) ? $urandom_range(1, 30) : (r < 95) ? $urandom_range(1, 4)
                                             : $urandom_range(20, 80);
        out_stall <= (r >= 65);
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    #100ms;
    $display("zbuffer_triangle_raster test failed");
    $finish;
  end

  initial begin
    logic [8:0] settings_w [6] = '{256, 16, 0, 511, 3, 100};
    logic [8:0] settings_h [6] = '{256, 16, 0, 300, 5, 2};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty read, both windings, degenerate, depth loses, clipping
    read_px(16'd0);
    draw(0, 0, 100, 4, 0, 100, 0, 4, 100, 32'hFFFF_FFFF);
    draw(0, 0, 32767, 0, 4, 32767, 4, 0, 32767, 32'h1234_5678);
    draw(0, 0, 5, 2, 2, 6, 4, 4, 7, 32'hDEAD_BEEF);
    draw(7, 7, 1, 7, 7, 2, 7, 7, 3, 32'hCAFE_F00D);
    draw(0, 0, -32768, 4, 0, -32768, 0, 4, -32768, 32'h0BAD_0BAD);
    draw(-2048, -2048, -32768, -2000, -2048, 32767, -2048, -2000, 0, 32'h0);
    draw(2047, 2047, 32767, 2000, 2047, -32768, 2047, 2000, 1, 32'hA5A5_A5A5);
    draw(-3, -3, -200, 5, -3, 300, -3, 5, 1000, 32'h5A5A_5A5A);
    draw(250, 250, 10, 260, 253, -10, 253, 260, 20, 32'h8000_0001);
    read_px(16'd0);
    read_px(16'd0);
    read_px(16'd1);
    read_px(16'd256);
    read_px(16'd65535);
    read_px(16'(253 * 256 + 253));
    drain();

    // Tiny frame: a huge triangle clamps to it
    write_frame(9'd5, 9'd3);
    draw(-2048, -2048, 32767, 2047, -2048, -32768, -2048, 2047, 12, 32'h7F7F_7F7F);
    read_px(16'd0);
    read_px(16'd14);
    read_px(16'd7);
    drain();

    // Random phases over several frame settings
    hold_req = 1'b1;
    for (int p = 0; p < 6; p++) begin
      write_frame(settings_w[p], settings_h[p]);
      for (int i = 0; i < 92; i++) begin
        if ($urandom_range(0, 99) < 70) random_draw();
        else random_read();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Sent %0d draws and %0d reads over %0d frame settings", n_draws, n_reads,
             n_settings);
    $display("%0d pixels passed the depth test, %0d degenerate triangles", pixels_total,
             degen_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("zbuffer_triangle_raster test passed");
    end else begin
      $display("zbuffer_triangle_raster test failed");
    end
    $finish;
  end

endmodule
